>>> rtl/mbapfr_pkg.sv
package mbapfr_pkg;

    localparam int unsigned MAX_RTU_BYTES = 260;
    localparam logic [15:0] LEN_LIMIT     = 16'(MAX_RTU_BYTES - 2);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] MODE_HEADER  = 2'd0;
    localparam logic [1:0] MODE_FORWARD = 2'd1;
    localparam logic [1:0] MODE_DROP    = 2'd2;

    localparam logic [1:0] ST_RTU_BYTE  = 2'd0;
    localparam logic [1:0] ST_BAD_PROTO = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_TOO_LONG  = 2'd3;

    localparam logic [2:0] HDR_TRANS_HI = 3'd0;
    localparam logic [2:0] HDR_TRANS_LO = 3'd1;
    localparam logic [2:0] HDR_PROTO_HI = 3'd2;
    localparam logic [2:0] HDR_PROTO_LO = 3'd3;
    localparam logic [2:0] HDR_LEN_HI   = 3'd4;
    localparam logic [2:0] HDR_LEN_LO   = 3'd5;
    localparam logic [2:0] HDR_UNIT     = 3'd6;
    localparam logic [2:0] HDR_UNIT_ALT = 3'd7;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned BEATS_MAX   = 3;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_last;
        logic [1:0]  status;
        logic [15:0] transaction_id;
        logic [7:0]  unit_id;
        logic [7:0]  function_code;
    } beat_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic [1:0] bad_code(input logic [15:0] len, input logic [15:0] proto);
        if (len < 16'd2)
            return ST_BAD_LEN;
        else if (proto != 16'd0)
            return ST_BAD_PROTO;
        else if (len > LEN_LIMIT)
            return ST_TOO_LONG;
        else
            return ST_RTU_BYTE;
    endfunction

endpackage

>>> rtl/mbap_to_rtu_request_framer_unit.sv
// A result beat is written into the queue when its input byte is accepted.
// Throughput: one input byte per cycle unless stalled; for a forwarded frame
// the last PDU byte yields three beats (data, CRC low, CRC high) that drain
// one per cycle from a 4-entry queue unless rtu_stall is high. The input
// stalls while the queue holds more than one beat. Reset: header parser at
// the first MBAP byte, holds zero, CRC at 0xFFFF, result queue empty.
module mbap_to_rtu_request_framer_unit
    import mbapfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tcp_valid,
    output logic        tcp_stall,
    input  logic [7:0]  tcp_byte,
    output logic        rtu_valid,
    input  logic        rtu_stall,
    output logic [7:0]  out_byte,
    output logic        frame_last,
    output logic [1:0]  status,
    output logic [15:0] transaction_id,
    output logic [7:0]  unit_id,
    output logic [7:0]  function_code
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned NUM_W = $clog2(BEATS_MAX + 1);

    logic [2:0]  header_index_reg, header_index_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] transaction_reg, transaction_next;
    logic [15:0] protocol_reg, protocol_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  unit_reg, unit_next;
    logic [7:0]  function_reg, function_next;
    logic [15:0] crc_reg, crc_next;
    logic [1:0]  mode_reg, mode_next;

    beat_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    beat_t             beat [BEATS_MAX];
    logic [NUM_W-1:0]  push_num;
    logic              in_fire;
    logic              out_fire;

    logic [15:0] bl_dec;
    logic [15:0] crc_fed;
    logic [1:0]  code;

    assign tcp_stall = count_reg > CNT_W'(QUEUE_DEPTH - BEATS_MAX);
    assign in_fire   = tcp_valid && !tcp_stall;
    assign rtu_valid = count_reg != '0;
    assign out_fire  = rtu_valid && !rtu_stall;

    assign out_byte       = queue_reg[rd_ptr_reg].out_byte;
    assign frame_last     = queue_reg[rd_ptr_reg].frame_last;
    assign status         = queue_reg[rd_ptr_reg].status;
    assign transaction_id = queue_reg[rd_ptr_reg].transaction_id;
    assign unit_id        = queue_reg[rd_ptr_reg].unit_id;
    assign function_code  = queue_reg[rd_ptr_reg].function_code;

    always_comb
    begin
        header_index_next = header_index_reg;
        bytes_left_next   = bytes_left_reg;
        transaction_next  = transaction_reg;
        protocol_next     = protocol_reg;
        length_next       = length_reg;
        unit_next         = unit_reg;
        function_next     = function_reg;
        crc_next          = crc_reg;
        mode_next         = mode_reg;
        push_num          = '0;
        bl_dec            = '0;
        crc_fed           = '0;
        code              = ST_RTU_BYTE;
        for (int k = 0; k < BEATS_MAX; k++)
            beat[k] = '0;

        if (in_fire) begin
            if (mode_reg == MODE_FORWARD || mode_reg == MODE_DROP) begin
                if ({1'b0, bytes_left_reg} + 17'd1 == {1'b0, length_reg})
                    function_next = tcp_byte;
                bl_dec = (bytes_left_reg != 16'd0) ? bytes_left_reg - 16'd1 : 16'd0;
                bytes_left_next = bl_dec;
                if (mode_reg == MODE_FORWARD) begin
                    crc_fed  = crc_feed(crc_reg, tcp_byte);
                    crc_next = crc_fed;
                    beat[0]  = '{tcp_byte, 1'b0, ST_RTU_BYTE, transaction_reg, unit_reg,
                                 function_next};
                    push_num = NUM_W'(1);
                    if (bl_dec == 16'd0) begin
                        beat[1]   = '{crc_fed[7:0], 1'b0, ST_RTU_BYTE, transaction_reg,
                                      unit_reg, function_next};
                        beat[2]   = '{crc_fed[15:8], 1'b1, ST_RTU_BYTE, transaction_reg,
                                      unit_reg, function_next};
                        push_num  = NUM_W'(3);
                        mode_next = MODE_HEADER;
                    end
                end
                else if (bl_dec == 16'd0) begin
                    beat[0]   = '{8'h00, 1'b1, bad_code(length_reg, protocol_reg),
                                  transaction_reg, unit_reg, function_next};
                    push_num  = NUM_W'(1);
                    mode_next = MODE_HEADER;
                end
            end
            else begin
                mode_next = MODE_HEADER;
                unique case (header_index_reg)
                    HDR_TRANS_HI:
                    begin
                        transaction_next  = {tcp_byte, 8'h00};
                        function_next     = 8'h00;
                        crc_next          = CRC_INIT;
                        header_index_next = HDR_TRANS_LO;
                    end
                    HDR_TRANS_LO:
                    begin
                        transaction_next  = {transaction_reg[15:8], tcp_byte};
                        header_index_next = HDR_PROTO_HI;
                    end
                    HDR_PROTO_HI:
                    begin
                        protocol_next     = {tcp_byte, 8'h00};
                        header_index_next = HDR_PROTO_LO;
                    end
                    HDR_PROTO_LO:
                    begin
                        protocol_next     = {protocol_reg[15:8], tcp_byte};
                        header_index_next = HDR_LEN_HI;
                    end
                    HDR_LEN_HI:
                    begin
                        length_next       = {tcp_byte, 8'h00};
                        header_index_next = HDR_LEN_LO;
                    end
                    HDR_LEN_LO:
                    begin
                        length_next       = {length_reg[15:8], tcp_byte};
                        header_index_next = HDR_UNIT;
                    end
                    HDR_UNIT, HDR_UNIT_ALT:
                    begin
                        unit_next         = tcp_byte;
                        header_index_next = HDR_TRANS_HI;
                        code              = bad_code(length_reg, protocol_reg);
                        bl_dec = (length_reg != 16'd0) ? length_reg - 16'd1 : 16'd0;
                        bytes_left_next   = bl_dec;
                        if (code != ST_RTU_BYTE) begin
                            if (bl_dec == 16'd0) begin
                                beat[0]  = '{8'h00, 1'b1, code, transaction_reg, tcp_byte,
                                             function_reg};
                                push_num = NUM_W'(1);
                            end
                            else begin
                                mode_next = MODE_DROP;
                            end
                        end
                        else begin
                            crc_next  = crc_feed(CRC_INIT, tcp_byte);
                            beat[0]   = '{tcp_byte, 1'b0, ST_RTU_BYTE, transaction_reg,
                                          tcp_byte, function_reg};
                            push_num  = NUM_W'(1);
                            mode_next = MODE_FORWARD;
                        end
                    end
                endcase
            end
        end

        wr_ptr_next = wr_ptr_reg + PTR_W'(push_num);
        rd_ptr_next = out_fire ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_num) - (out_fire ? CNT_W'(1) : CNT_W'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            header_index_reg <= HDR_TRANS_HI;
            bytes_left_reg   <= '0;
            transaction_reg  <= '0;
            protocol_reg     <= '0;
            length_reg       <= '0;
            unit_reg         <= '0;
            function_reg     <= '0;
            crc_reg          <= CRC_INIT;
            mode_reg         <= MODE_HEADER;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else begin
            header_index_reg <= header_index_next;
            bytes_left_reg   <= bytes_left_next;
            transaction_reg  <= transaction_next;
            protocol_reg     <= protocol_next;
            length_reg       <= length_next;
            unit_reg         <= unit_next;
            function_reg     <= function_next;
            crc_reg          <= crc_next;
            mode_reg         <= mode_next;
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            count_reg        <= count_next;
        end
    end

    // write up to three beats at consecutive queue slots
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < BEATS_MAX; k++) begin
            if (NUM_W'(k) < push_num)
                queue_reg[wr_ptr_reg + PTR_W'(k)] <= beat[k];
        end
    end

endmodule

>>> dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbapfr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SHORT_BYTES  = 100;

    typedef enum int {PH_STEADY, PH_SRC_GAPS, PH_SNK_STALLS, PH_BOTH} phase_e;

    typedef struct {
        logic [7:0] b;
        phase_e     ph;
        bit         drain;
    } stim_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        tcp_valid = 1'b0;
    logic        tcp_stall;
    logic [7:0]  tcp_byte  = 8'h00;
    logic        rtu_valid;
    logic        rtu_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        frame_last;
    logic [1:0]  status;
    logic [15:0] transaction_id;
    logic [7:0]  unit_id;
    logic [7:0]  function_code;

    stim_t  tcp_pending[$];
    beat_t  rtu_expected[$];
    phase_e rx_phase    = PH_STEADY;
    int     errors      = 0;
    int     cycle_count = 0;

    logic [2:0]  hdr_pos   = HDR_TRANS_HI;
    logic [15:0] left_cnt  = 16'h0000;
    logic [15:0] trans_reg = 16'h0000;
    logic [15:0] proto_reg = 16'h0000;
    logic [15:0] len_reg   = 16'h0000;
    logic [7:0]  unit_reg  = 8'h00;
    logic [7:0]  func_reg  = 8'h00;
    logic [15:0] crc_reg   = CRC_INIT;
    logic [1:0]  mode_reg  = MODE_HEADER;

    mbap_to_rtu_request_framer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .tcp_valid      (tcp_valid),
        .tcp_stall      (tcp_stall),
        .tcp_byte       (tcp_byte),
        .rtu_valid      (rtu_valid),
        .rtu_stall      (rtu_stall),
        .out_byte       (out_byte),
        .frame_last     (frame_last),
        .status         (status),
        .transaction_id (transaction_id),
        .unit_id        (unit_id),
        .function_code  (function_code)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            r = (r[0] ^ d[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic logic [1:0] header_fault();
        if (len_reg < 16'd2)
            return ST_BAD_LEN;
        if (proto_reg != 16'd0)
            return ST_BAD_PROTO;
        if (32'(len_reg) + 32'd2 > 32'(MAX_RTU_BYTES))
            return ST_TOO_LONG;
        return ST_RTU_BYTE;
    endfunction

    task automatic expect_beat(input logic [7:0] b, input logic last, input logic [1:0] st);
        beat_t e;
        e.out_byte       = b;
        e.frame_last     = last;
        e.status         = st;
        e.transaction_id = trans_reg;
        e.unit_id        = unit_reg;
        e.function_code  = func_reg;
        rtu_expected.push_back(e);
    endtask

    task automatic parse_tcp_byte(input logic [7:0] b);
        logic [1:0] code;
        if (mode_reg == MODE_FORWARD || mode_reg == MODE_DROP)
        begin
            if (17'(left_cnt) + 17'd1 == 17'(len_reg))
                func_reg = b;
            if (left_cnt != 16'd0)
                left_cnt = left_cnt - 16'd1;
            if (mode_reg == MODE_FORWARD)
            begin
                crc_reg = crc16_modbus(crc_reg, b);
                expect_beat(b, 1'b0, ST_RTU_BYTE);
                if (left_cnt == 16'd0)
                begin
                    expect_beat(crc_reg[7:0], 1'b0, ST_RTU_BYTE);
                    expect_beat(crc_reg[15:8], 1'b1, ST_RTU_BYTE);
                    mode_reg = MODE_HEADER;
                end
            end
            else if (left_cnt == 16'd0)
            begin
                expect_beat(8'h00, 1'b1, header_fault());
                mode_reg = MODE_HEADER;
            end
            return;
        end
        mode_reg = MODE_HEADER;
        case (hdr_pos)
            HDR_TRANS_HI:
            begin
                trans_reg = {b, 8'h00};
                func_reg  = 8'h00;
                crc_reg   = CRC_INIT;
                hdr_pos   = HDR_TRANS_LO;
            end
            HDR_TRANS_LO:
            begin
                trans_reg[7:0] = b;
                hdr_pos        = HDR_PROTO_HI;
            end
            HDR_PROTO_HI:
            begin
                proto_reg = {b, 8'h00};
                hdr_pos   = HDR_PROTO_LO;
            end
            HDR_PROTO_LO:
            begin
                proto_reg[7:0] = b;
                hdr_pos        = HDR_LEN_HI;
            end
            HDR_LEN_HI:
            begin
                len_reg = {b, 8'h00};
                hdr_pos = HDR_LEN_LO;
            end
            HDR_LEN_LO:
            begin
                len_reg[7:0] = b;
                hdr_pos      = HDR_UNIT;
            end
            default:
            begin
                unit_reg = b;
                hdr_pos  = HDR_TRANS_HI;
                code     = header_fault();
                left_cnt = (len_reg != 16'd0) ? len_reg - 16'd1 : 16'd0;
                if (code != ST_RTU_BYTE)
                begin
                    if (left_cnt == 16'd0)
                        expect_beat(8'h00, 1'b1, code);
                    else
                        mode_reg = MODE_DROP;
                end
                else
                begin
                    crc_reg = crc16_modbus(CRC_INIT, b);
                    expect_beat(b, 1'b0, ST_RTU_BYTE);
                    mode_reg = MODE_FORWARD;
                end
            end
        endcase
    endtask

    function automatic bit take_gap(input phase_e ph, input bit sink);
        int pct;
        case (ph)
            PH_SRC_GAPS:   pct = sink ? 0 : 81;
            PH_SNK_STALLS: pct = sink ? 81 : 0;
            PH_BOTH:       pct = 29;
            default:       pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, what, want, got);
            errors++;
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input phase_e ph, input bit drain);
        stim_t s;
        s.b     = b;
        s.ph    = ph;
        s.drain = drain;
        tcp_pending.push_back(s);
    endtask

    task automatic add_header(input logic [15:0] trans, input logic [15:0] proto,
                              input logic [15:0] len, input logic [7:0] unit,
                              input phase_e ph, input bit drain);
        add_byte(trans[15:8], ph, drain);
        add_byte(trans[7:0], ph, 1'b0);
        add_byte(proto[15:8], ph, 1'b0);
        add_byte(proto[7:0], ph, 1'b0);
        add_byte(len[15:8], ph, 1'b0);
        add_byte(len[7:0], ph, 1'b0);
        add_byte(unit, ph, 1'b0);
    endtask

    task automatic add_body(input int count, input phase_e ph);
        for (int i = 0; i < count; i++)
        begin
            add_byte(8'($urandom), ph, 1'b0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcp_valid <= 1'b0;
            tcp_byte  <= 8'h00;
        end
        else
        begin
            if (tcp_valid && !tcp_stall)
                parse_tcp_byte(tcp_byte);
            if (!tcp_valid || !tcp_stall)
            begin
                if (tcp_pending.size() != 0
                    && !(tcp_pending[0].drain && rtu_expected.size() != 0)
                    && !take_gap(tcp_pending[0].ph, 1'b0))
                begin
                    tcp_valid <= 1'b1;
                    tcp_byte  <= tcp_pending[0].b;
                    rx_phase  <= tcp_pending[0].ph;
                    tcp_pending.pop_front();
                end
                else
                begin
                    tcp_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : rtu_monitor
        beat_t want;
        if (!rst_n)
        begin
            rtu_stall <= 1'b0;
        end
        else
        begin
            if (rtu_valid && !rtu_stall)
            begin
                if (rtu_expected.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual byte %h status %h",
                             $realtime, out_byte, status);
                    errors++;
                end
                else
                begin
                    want = rtu_expected.pop_front();
                    check_field("out_byte", 16'(want.out_byte), 16'(out_byte));
                    check_field("frame_last", 16'(want.frame_last), 16'(frame_last));
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("transaction_id", want.transaction_id, transaction_id);
                    check_field("unit_id", 16'(want.unit_id), 16'(unit_id));
                    check_field("function_code", 16'(want.function_code), 16'(function_code));
                end
            end
            rtu_stall <= take_gap(rx_phase, 1'b1);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        logic [15:0] trans;
        logic [15:0] proto;
        logic [15:0] len;
        int          short_bytes;
        int          pick;
        int          body;
        phase_e      ph;
        bit          drain;

        add_header(16'hFFFF, 16'h0000, 16'd2, 8'hFF, PH_STEADY, 1'b0);
        add_byte(8'hFF, PH_STEADY, 1'b0);
        add_header(16'h0000, 16'hFFFF, 16'd0, 8'h00, PH_STEADY, 1'b0);
        add_header(16'h1234, 16'h0001, 16'd3, 8'h11, PH_STEADY, 1'b0);
        add_body(2, PH_STEADY);

        // shortest frame that no longer fits
        add_header(16'($urandom), 16'h0000, 16'(MAX_RTU_BYTES - 1), 8'($urandom),
                   PH_BOTH, 1'b1);
        add_body(MAX_RTU_BYTES - 2, PH_BOTH);

        short_bytes = 0;
        while (short_bytes < SHORT_BYTES)
        begin
            ph    = phase_e'(short_bytes * 4 / SHORT_BYTES);
            drain = (short_bytes == 0) || ($urandom_range(99) < 5);
            trans = 16'($urandom);
            pick  = $urandom_range(99);
            if (pick < 75)
            begin
                proto = 16'h0000;
                len   = 16'($urandom_range(2, 12));
            end
            else if (pick < 88)
            begin
                proto = 16'($urandom_range(1, 65535));
                len   = 16'($urandom_range(0, 12));
            end
            else
            begin
                proto = 16'($urandom);
                len   = 16'($urandom_range(0, 1));
            end
            body = (len != 16'd0) ? int'(len) - 1 : 0;
            add_header(trans, proto, len, 8'($urandom), ph, drain);
            add_body(body, ph);
            short_bytes += 7 + body;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (tcp_pending.size() != 0 || tcp_valid || rtu_expected.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (errors == 0 && rtu_expected.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

>>> mbap_to_rtu_request_framer_unit.f
rtl/mbapfr_pkg.sv
rtl/mbap_to_rtu_request_framer_unit.sv
dv/tb.sv
